FILE: src/esc_pkg.sv
package esc_pkg;

	// Kind codes carried on op and kind.
	localparam logic [1:0] KIND_TEMP = 2'd0;
	localparam logic [1:0] KIND_PRES = 2'd1;
	localparam logic [1:0] KIND_HUM  = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] CFG_TEMP      = 3'd0;
	localparam logic [2:0] CFG_PRES_LOW  = 3'd1;
	localparam logic [2:0] CFG_PRES_HIGH = 3'd2;
	localparam logic [2:0] CFG_PRES_LAST = 3'd3;
	localparam logic [2:0] CFG_HUM       = 3'd4;

	// Microprogram entry points.
	localparam logic [6:0] PC_TEMP = 7'd0;
	localparam logic [6:0] PC_PRES = 7'd18;
	localparam logic [6:0] PC_HUM  = 7'd53;
	localparam logic [6:0] PC_NONE = 7'd82;

	typedef enum logic [3:0] {
		OP_ADD,
		OP_SUB,
		OP_SHL,
		OP_SHR,
		OP_MUL,
		OP_DIV,
		OP_CLT,
		OP_CLP,
		OP_CLH,
		OP_SETF,
		OP_FIN
	} op_t;

	typedef enum logic [4:0] {
		S_R0, S_R1, S_R2, S_R3, S_R4, S_R5, S_R6, S_R7,
		S_RAW, S_RAWH, S_FINE, S_IMM,
		S_T1, S_T2, S_T3,
		S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
		S_H1, S_H2, S_H3, S_H4, S_H5, S_H6
	} src_t;

	typedef struct packed {
		op_t                op;
		logic [2:0]         dst;
		src_t               a;
		src_t               b;
		logic [5:0]         sh;
		logic signed [23:0] imm;
	} instr_t;

	function automatic instr_t mk(input op_t op, input logic [2:0] dst, input src_t a,
			input src_t b, input logic [5:0] sh, input logic signed [23:0] imm);
		instr_t i;
		i.op  = op;
		i.dst = dst;
		i.a   = a;
		i.b   = b;
		i.sh  = sh;
		i.imm = imm;
		return i;
	endfunction

	// Compensation microprogram: temperature, pressure, humidity, unused kind.
	function automatic instr_t rom(input logic [6:0] pc);
		instr_t i;
		case (pc)
			// Temperature
			7'd0:  i = mk(OP_SHR, 3'd0, S_RAW, S_R0, 6'd3, 24'sd0);
			7'd1:  i = mk(OP_SHL, 3'd1, S_T1, S_R0, 6'd1, 24'sd0);
			7'd2:  i = mk(OP_SUB, 3'd0, S_R0, S_R1, 6'd0, 24'sd0);
			7'd3:  i = mk(OP_MUL, 3'd0, S_R0, S_T2, 6'd0, 24'sd0);
			7'd4:  i = mk(OP_SHR, 3'd0, S_R0, S_R0, 6'd11, 24'sd0);
			7'd5:  i = mk(OP_SHR, 3'd1, S_RAW, S_R0, 6'd4, 24'sd0);
			7'd6:  i = mk(OP_SUB, 3'd1, S_R1, S_T1, 6'd0, 24'sd0);
			7'd7:  i = mk(OP_MUL, 3'd1, S_R1, S_R1, 6'd0, 24'sd0);
			7'd8:  i = mk(OP_SHR, 3'd1, S_R1, S_R0, 6'd12, 24'sd0);
			7'd9:  i = mk(OP_MUL, 3'd1, S_R1, S_T3, 6'd0, 24'sd0);
			7'd10: i = mk(OP_SHR, 3'd1, S_R1, S_R0, 6'd14, 24'sd0);
			7'd11: i = mk(OP_ADD, 3'd0, S_R0, S_R1, 6'd0, 24'sd0);
			7'd12: i = mk(OP_SETF, 3'd0, S_R0, S_R0, 6'd0, 24'sd0);
			7'd13: i = mk(OP_MUL, 3'd0, S_R0, S_IMM, 6'd0, 24'sd5);
			7'd14: i = mk(OP_ADD, 3'd0, S_R0, S_IMM, 6'd0, 24'sd128);
			7'd15: i = mk(OP_SHR, 3'd0, S_R0, S_R0, 6'd8, 24'sd0);
			7'd16: i = mk(OP_CLT, 3'd0, S_R0, S_R0, 6'd0, 24'sd0);
			7'd17: i = mk(OP_FIN, 3'd0, S_R0, S_R0, 6'd0, 24'sd0);
			// Pressure
			7'd18: i = mk(OP_SUB, 3'd0, S_FINE, S_IMM, 6'd0, 24'sd128000);
			7'd19: i = mk(OP_MUL, 3'd1, S_R0, S_R0, 6'd0, 24'sd0);
			7'd20: i = mk(OP_MUL, 3'd2, S_R1, S_P6, 6'd0, 24'sd0);
			7'd21: i = mk(OP_MUL, 3'd3, S_R0, S_P5, 6'd0, 24'sd0);
			7'd22: i = mk(OP_SHL, 3'd3, S_R3, S_R0, 6'd17, 24'sd0);
			7'd23: i = mk(OP_ADD, 3'd2, S_R2, S_R3, 6'd0, 24'sd0);
			7'd24: i = mk(OP_SHL, 3'd3, S_P4, S_R0, 6'd35, 24'sd0);
			7'd25: i = mk(OP_ADD, 3'd2, S_R2, S_R3, 6'd0, 24'sd0);
			7'd26: i = mk(OP_MUL, 3'd1, S_R1, S_P3, 6'd0, 24'sd0);
			7'd27: i = mk(OP_SHR, 3'd1, S_R1, S_R0, 6'd8, 24'sd0);
			7'd28: i = mk(OP_MUL, 3'd3, S_R0, S_P2, 6'd0, 24'sd0);
			7'd29: i = mk(OP_SHL, 3'd3, S_R3, S_R0, 6'd12, 24'sd0);
			7'd30: i = mk(OP_ADD, 3'd0, S_R1, S_R3, 6'd0, 24'sd0);
			7'd31: i = mk(OP_SHL, 3'd1, S_IMM, S_R0, 6'd47, 24'sd1);
			7'd32: i = mk(OP_ADD, 3'd0, S_R1, S_R0, 6'd0, 24'sd0);
			7'd33: i = mk(OP_MUL, 3'd0, S_R0, S_P1, 6'd0, 24'sd0);
			7'd34: i = mk(OP_SHR, 3'd0, S_R0, S_R0, 6'd33, 24'sd0);
			7'd35: i = mk(OP_SUB, 3'd1, S_IMM, S_RAW, 6'd0, 24'sd1048576);
			7'd36: i = mk(OP_SHL, 3'd1, S_R1, S_R0, 6'd31, 24'sd0);
			7'd37: i = mk(OP_SUB, 3'd1, S_R1, S_R2, 6'd0, 24'sd0);
			7'd38: i = mk(OP_MUL, 3'd1, S_R1, S_IMM, 6'd0, 24'sd3125);
			7'd39: i = mk(OP_DIV, 3'd1, S_R1, S_R0, 6'd0, 24'sd0);
			7'd40: i = mk(OP_SHR, 3'd2, S_R1, S_R0, 6'd13, 24'sd0);
			7'd41: i = mk(OP_MUL, 3'd3, S_P9, S_R2, 6'd0, 24'sd0);
			7'd42: i = mk(OP_MUL, 3'd3, S_R3, S_R2, 6'd0, 24'sd0);
			7'd43: i = mk(OP_SHR, 3'd3, S_R3, S_R0, 6'd25, 24'sd0);
			7'd44: i = mk(OP_MUL, 3'd4, S_P8, S_R1, 6'd0, 24'sd0);
			7'd45: i = mk(OP_SHR, 3'd4, S_R4, S_R0, 6'd19, 24'sd0);
			7'd46: i = mk(OP_ADD, 3'd1, S_R1, S_R3, 6'd0, 24'sd0);
			7'd47: i = mk(OP_ADD, 3'd1, S_R1, S_R4, 6'd0, 24'sd0);
			7'd48: i = mk(OP_SHR, 3'd1, S_R1, S_R0, 6'd8, 24'sd0);
			7'd49: i = mk(OP_SHL, 3'd3, S_P7, S_R0, 6'd4, 24'sd0);
			7'd50: i = mk(OP_ADD, 3'd1, S_R1, S_R3, 6'd0, 24'sd0);
			7'd51: i = mk(OP_CLP, 3'd1, S_R1, S_R0, 6'd0, 24'sd0);
			7'd52: i = mk(OP_FIN, 3'd0, S_R1, S_R0, 6'd0, 24'sd0);
			// Humidity
			7'd53: i = mk(OP_SUB, 3'd0, S_FINE, S_IMM, 6'd0, 24'sd76800);
			7'd54: i = mk(OP_SHL, 3'd1, S_RAWH, S_R0, 6'd14, 24'sd0);
			7'd55: i = mk(OP_SHL, 3'd2, S_H4, S_R0, 6'd20, 24'sd0);
			7'd56: i = mk(OP_SUB, 3'd1, S_R1, S_R2, 6'd0, 24'sd0);
			7'd57: i = mk(OP_MUL, 3'd2, S_H5, S_R0, 6'd0, 24'sd0);
			7'd58: i = mk(OP_SUB, 3'd1, S_R1, S_R2, 6'd0, 24'sd0);
			7'd59: i = mk(OP_ADD, 3'd1, S_R1, S_IMM, 6'd0, 24'sd16384);
			7'd60: i = mk(OP_SHR, 3'd1, S_R1, S_R0, 6'd15, 24'sd0);
			7'd61: i = mk(OP_MUL, 3'd2, S_R0, S_H6, 6'd0, 24'sd0);
			7'd62: i = mk(OP_SHR, 3'd2, S_R2, S_R0, 6'd10, 24'sd0);
			7'd63: i = mk(OP_MUL, 3'd3, S_R0, S_H3, 6'd0, 24'sd0);
			7'd64: i = mk(OP_SHR, 3'd3, S_R3, S_R0, 6'd11, 24'sd0);
			7'd65: i = mk(OP_ADD, 3'd3, S_R3, S_IMM, 6'd0, 24'sd32768);
			7'd66: i = mk(OP_MUL, 3'd2, S_R2, S_R3, 6'd0, 24'sd0);
			7'd67: i = mk(OP_SHR, 3'd2, S_R2, S_R0, 6'd10, 24'sd0);
			7'd68: i = mk(OP_ADD, 3'd2, S_R2, S_IMM, 6'd0, 24'sd2097152);
			7'd69: i = mk(OP_MUL, 3'd2, S_R2, S_H2, 6'd0, 24'sd0);
			7'd70: i = mk(OP_ADD, 3'd2, S_R2, S_IMM, 6'd0, 24'sd8192);
			7'd71: i = mk(OP_SHR, 3'd2, S_R2, S_R0, 6'd14, 24'sd0);
			7'd72: i = mk(OP_MUL, 3'd0, S_R1, S_R2, 6'd0, 24'sd0);
			7'd73: i = mk(OP_SHR, 3'd3, S_R0, S_R0, 6'd15, 24'sd0);
			7'd74: i = mk(OP_MUL, 3'd3, S_R3, S_R3, 6'd0, 24'sd0);
			7'd75: i = mk(OP_SHR, 3'd3, S_R3, S_R0, 6'd7, 24'sd0);
			7'd76: i = mk(OP_MUL, 3'd3, S_R3, S_H1, 6'd0, 24'sd0);
			7'd77: i = mk(OP_SHR, 3'd3, S_R3, S_R0, 6'd4, 24'sd0);
			7'd78: i = mk(OP_SUB, 3'd0, S_R0, S_R3, 6'd0, 24'sd0);
			7'd79: i = mk(OP_CLH, 3'd0, S_R0, S_R0, 6'd0, 24'sd0);
			7'd80: i = mk(OP_SHR, 3'd0, S_R0, S_R0, 6'd12, 24'sd0);
			7'd81: i = mk(OP_FIN, 3'd0, S_R0, S_R0, 6'd0, 24'sd0);
			// Unused kind: reading zero
			default: i = mk(OP_FIN, 3'd0, S_IMM, S_IMM, 6'd0, 24'sd0);
		endcase
		return i;
	endfunction

endpackage

FILE: src/environmental_sensor_compensation.sv
// One item at a time: a new input is taken only once the previous result has been
// accepted. A step runs in an operand-read state and then an execute state; a step with
// a 64-bit product continues on the shared 32x32 multiplier, and the pressure division
// on the one-bit-per-cycle divider. Reset (arst_n low) clears calibration words,
// fine temperature and all control state; the scratch register file needs no clearing.
module environmental_sensor_compensation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [19:0]        raw_reading,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic signed [32:0] reading,
	output logic               divide_fault
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_FETCH = 6'b000010,
		ST_EXEC  = 6'b000100,
		ST_MUL   = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	logic [6:0] pc_q;
	logic [1:0] kind_q;
	logic [19:0] raw_q;
	logic signed [32:0] reading_q;
	logic fault_q;
	logic signed [31:0] fine_q;
	logic [47:0] cal_t_q;
	logic [63:0] cal_pl_q;
	logic [63:0] cal_ph_q;
	logic [15:0] cal_plast_q;
	logic [63:0] cal_h_q;

	logic [63:0] rf_q [8];
	logic [63:0] rda_q;
	logic [63:0] rdb_q;

	logic [1:0] mc_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;

	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] dmag_q;
	logic qneg_q;
	logic [5:0] cnt_q;

	esc_pkg::instr_t ins;
	logic signed [63:0] va;
	logic signed [63:0] vb;
	logic signed [63:0] alu;
	logic [31:0] mul_x;
	logic [31:0] mul_y;
	logic [63:0] mul_sum;
	logic [64:0] div_shift;
	logic [64:0] div_diff;
	logic [63:0] quo_next;
	logic [63:0] rem_next;
	logic [63:0] quo_fin;
	logic wr_en;
	logic [63:0] wr_data;

	assign ins = esc_pkg::rom(pc_q);

	// Operand selection: scratch registers, the reading, fine temperature, calibration fields or immediate.
	function automatic logic signed [63:0] pick(input esc_pkg::src_t s, input logic [63:0] rd,
			input logic [19:0] raw, input logic signed [31:0] fine,
			input logic signed [23:0] imm, input logic [47:0] ct, input logic [63:0] pl,
			input logic [63:0] ph, input logic [15:0] plast, input logic [63:0] ch);
		logic signed [63:0] v;
		case (s)
			esc_pkg::S_RAW:  v = {44'd0, raw};
			esc_pkg::S_RAWH: v = {48'd0, raw[15:0]};
			esc_pkg::S_FINE: v = {{32{fine[31]}}, fine};
			esc_pkg::S_IMM:  v = {{40{imm[23]}}, imm};
			esc_pkg::S_T1:   v = {48'd0, ct[15:0]};
			esc_pkg::S_T2:   v = {{48{ct[31]}}, ct[31:16]};
			esc_pkg::S_T3:   v = {{48{ct[47]}}, ct[47:32]};
			esc_pkg::S_P1:   v = {48'd0, pl[15:0]};
			esc_pkg::S_P2:   v = {{48{pl[31]}}, pl[31:16]};
			esc_pkg::S_P3:   v = {{48{pl[47]}}, pl[47:32]};
			esc_pkg::S_P4:   v = {{48{pl[63]}}, pl[63:48]};
			esc_pkg::S_P5:   v = {{48{ph[15]}}, ph[15:0]};
			esc_pkg::S_P6:   v = {{48{ph[31]}}, ph[31:16]};
			esc_pkg::S_P7:   v = {{48{ph[47]}}, ph[47:32]};
			esc_pkg::S_P8:   v = {{48{ph[63]}}, ph[63:48]};
			esc_pkg::S_P9:   v = {{48{plast[15]}}, plast};
			esc_pkg::S_H1:   v = {56'd0, ch[7:0]};
			esc_pkg::S_H2:   v = {{48{ch[23]}}, ch[23:8]};
			esc_pkg::S_H3:   v = {56'd0, ch[31:24]};
			esc_pkg::S_H4:   v = {{52{ch[43]}}, ch[43:32]};
			esc_pkg::S_H5:   v = {{52{ch[55]}}, ch[55:44]};
			esc_pkg::S_H6:   v = {{56{ch[63]}}, ch[63:56]};
			default:         v = rd;
		endcase
		return v;
	endfunction

	always_comb begin
		va = pick(ins.a, rda_q, raw_q, fine_q, ins.imm, cal_t_q, cal_pl_q, cal_ph_q,
			cal_plast_q, cal_h_q);
		vb = pick(ins.b, rdb_q, raw_q, fine_q, ins.imm, cal_t_q, cal_pl_q, cal_ph_q,
			cal_plast_q, cal_h_q);
	end

	// Combinational ALU operations, clamps included.
	always_comb begin
		case (ins.op)
			esc_pkg::OP_ADD: alu = va + vb;
			esc_pkg::OP_SUB: alu = va - vb;
			esc_pkg::OP_SHL: alu = va << ins.sh;
			esc_pkg::OP_SHR: alu = va >>> ins.sh;
			esc_pkg::OP_CLT: begin
				if (va < -64'sd4000)
					alu = -64'sd4000;
				else if (va > 64'sd8500)
					alu = 64'sd8500;
				else
					alu = va;
			end
			esc_pkg::OP_CLP: begin
				if (va < 64'sd0)
					alu = 64'sd0;
				else if (va > 64'sd4294967295)
					alu = 64'sd4294967295;
				else
					alu = va;
			end
			esc_pkg::OP_CLH: begin
				if (va < 64'sd0)
					alu = 64'sd0;
				else if (va > 64'sd419430400)
					alu = 64'sd419430400;
				else
					alu = va;
			end
			default: alu = va;
		endcase
	end

	// Shared multiplier: low 64 bits of a product from three 32x32 partial products.
	always_comb begin
		case (mc_q)
			2'd1: begin
				mul_x = va[63:32];
				mul_y = vb[31:0];
			end
			2'd2: begin
				mul_x = va[31:0];
				mul_y = vb[63:32];
			end
			default: begin
				mul_x = va[31:0];
				mul_y = vb[31:0];
			end
		endcase
		mul_sum = acc_q + {prod_q[31:0], 32'd0};
	end

	// Restoring divider step on magnitudes.
	always_comb begin
		div_shift = {rem_q, quo_q[63]};
		div_diff  = div_shift - {1'b0, dmag_q};
		if (!div_diff[64]) begin
			rem_next = div_diff[63:0];
			quo_next = {quo_q[62:0], 1'b1};
		end else begin
			rem_next = div_shift[63:0];
			quo_next = {quo_q[62:0], 1'b0};
		end
		quo_fin = qneg_q ? (64'd0 - quo_next) : quo_next;
	end

	// Register file write port.
	always_comb begin
		wr_en   = 1'b0;
		wr_data = alu;
		case (state_q)
			ST_EXEC: begin
				wr_en = (ins.op == esc_pkg::OP_ADD) || (ins.op == esc_pkg::OP_SUB) ||
					(ins.op == esc_pkg::OP_SHL) || (ins.op == esc_pkg::OP_SHR) ||
					(ins.op == esc_pkg::OP_CLT) || (ins.op == esc_pkg::OP_CLP) ||
					(ins.op == esc_pkg::OP_CLH);
			end
			ST_MUL: begin
				wr_en   = (mc_q == 2'd3);
				wr_data = mul_sum;
			end
			ST_DIV: begin
				wr_en   = (cnt_q == 6'd63);
				wr_data = quo_fin;
			end
			default: wr_en = 1'b0;
		endcase
	end

	// Scratch register file with registered reads.
	always_ff @(posedge clk) begin
		if (wr_en)
			rf_q[ins.dst] <= wr_data;
		rda_q <= rf_q[ins.a[2:0]];
		rdb_q <= rf_q[ins.b[2:0]];
	end

	// Arithmetic working registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_x * mul_y;
		if (state_q == ST_MUL) begin
			if (mc_q == 2'd1)
				acc_q <= prod_q;
			else
				acc_q <= mul_sum;
		end
		if (state_q == ST_EXEC) begin
			rem_q  <= 64'd0;
			quo_q  <= va[63] ? (64'd0 - va) : va;
			dmag_q <= vb[63] ? (64'd0 - vb) : vb;
			qneg_q <= va[63] ^ vb[63];
		end else if (state_q == ST_DIV) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
		end
	end

	// Calibration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_t_q     <= '0;
			cal_pl_q    <= '0;
			cal_ph_q    <= '0;
			cal_plast_q <= '0;
			cal_h_q     <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				esc_pkg::CFG_TEMP:      cal_t_q     <= cfg_data[47:0];
				esc_pkg::CFG_PRES_LOW:  cal_pl_q    <= cfg_data;
				esc_pkg::CFG_PRES_HIGH: cal_ph_q    <= cfg_data;
				esc_pkg::CFG_PRES_LAST: cal_plast_q <= cfg_data[15:0];
				esc_pkg::CFG_HUM:       cal_h_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pc_q      <= esc_pkg::PC_TEMP;
			mc_q      <= 2'd0;
			cnt_q     <= 6'd0;
			fine_q    <= '0;
			kind_q    <= '0;
			raw_q     <= '0;
			reading_q <= '0;
			fault_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						kind_q  <= op;
						raw_q   <= raw_reading;
						fault_q <= 1'b0;
						case (op)
							esc_pkg::KIND_TEMP: pc_q <= esc_pkg::PC_TEMP;
							esc_pkg::KIND_PRES: pc_q <= esc_pkg::PC_PRES;
							esc_pkg::KIND_HUM:  pc_q <= esc_pkg::PC_HUM;
							default:            pc_q <= esc_pkg::PC_NONE;
						endcase
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: state_q <= ST_EXEC;
				ST_EXEC: begin
					case (ins.op)
						esc_pkg::OP_MUL: begin
							mc_q    <= 2'd1;
							state_q <= ST_MUL;
						end
						esc_pkg::OP_DIV: begin
							if (vb == 64'sd0) begin
								reading_q <= '0;
								fault_q   <= 1'b1;
								state_q   <= ST_DONE;
							end else begin
								cnt_q   <= 6'd0;
								state_q <= ST_DIV;
							end
						end
						esc_pkg::OP_FIN: begin
							reading_q <= va[32:0];
							state_q   <= ST_DONE;
						end
						esc_pkg::OP_SETF: begin
							fine_q  <= va[31:0];
							pc_q    <= pc_q + 7'd1;
							state_q <= ST_FETCH;
						end
						default: begin
							pc_q    <= pc_q + 7'd1;
							state_q <= ST_FETCH;
						end
					endcase
				end
				ST_MUL: begin
					if (mc_q == 2'd3) begin
						mc_q    <= 2'd0;
						pc_q    <= pc_q + 7'd1;
						state_q <= ST_FETCH;
					end else begin
						mc_q <= mc_q + 2'd1;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						pc_q    <= pc_q + 7'd1;
						state_q <= ST_FETCH;
					end
				end
				ST_DONE: begin
					if (out_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Handshake and result outputs.
	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = (state_q == ST_DONE);
	assign kind         = kind_q;
	assign reading      = reading_q;
	assign divide_fault = fault_q;

endmodule
